@@ sv/lcm_pkg.sv @@
// ============================================================================
// lcm_pkg: shared definitions of the learned command matcher
// Result codes, command kinds, default sizes and the control and status
// bundles that pass between the controller and the datapath.
// ============================================================================
package lcm_pkg;

    // Default table size and longest learned string.
    localparam int DEFAULT_SLOT_COUNT = 16;
    localparam int DEFAULT_MAX_LEN    = 31;

    // Kind of a command, taken from its first byte.
    localparam logic KIND_LEARN = 1'b0;
    localparam logic KIND_MATCH = 1'b1;

    // Result code of a finished command.
    typedef enum logic [1:0] {
        STATUS_STORED   = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_MATCHED  = 2'd2,
        STATUS_NO_MATCH = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // take the request and access the pattern memory
        logic commit;   // compare, update state, register the result
    } lcm_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;     // the request in flight ends its command
    } lcm_sts_t;

endpackage

@@ sv/lcm_ctrl.sv @@
// ============================================================================
// lcm_ctrl: sequencing controller
// Accepts a request when idle, runs the evaluate cycle and raises the
// result strobe when the request closed a command.
// ============================================================================
module lcm_ctrl
    import lcm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  lcm_sts_t sts,
    output lcm_ctl_t ctl,
    output logic     busy,
    output logic     done
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        ctl.capture = (state_reg == ST_IDLE) && start;
        ctl.commit  = (state_reg == ST_EXEC);
        state_next  = state_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = sts.last;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

`ifndef SYNTH
    // Every accepted request is evaluated in the very next cycle.
    a_capture_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.capture |=> ctl.commit)
        else $error("accepted request was not evaluated");

    // The evaluate cycle never repeats back to back.
    a_single_commit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> !ctl.commit)
        else $error("evaluate cycle repeated");

    // A result strobe always follows an evaluate cycle.
    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctl.commit))
        else $error("result strobe without evaluation");
`endif

endmodule

@@ sv/lcm_datapath.sv @@
// ============================================================================
// lcm_datapath: pattern store and parallel comparison
// Holds the learned byte strings, their lengths and valid flags, tracks the
// byte position inside a command and compares all slots at once.
// ============================================================================
module lcm_datapath
    import lcm_pkg::*;
#(
    parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT,
    parameter int MAX_LEN    = DEFAULT_MAX_LEN
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  lcm_ctl_t   ctl,
    output lcm_sts_t   sts,
    input  logic       req_type,
    input  logic [3:0] slot,
    input  logic [7:0] data_byte,
    input  logic       last,
    output logic [1:0] status,
    output logic [2:0] line_index,
    output logic       line_mode
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CMP_W  = (SLOT_W > 4) ? SLOT_W : 4;
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int POS_W  = $clog2(MAX_LEN + 2);
    localparam int INC_W  = POS_W + 1;
    localparam int LEN_W  = $clog2(MAX_LEN + 1);

    typedef logic [SLOT_COUNT-1:0][7:0] row_t;

    // Pattern memory: one row per byte position, one byte lane per slot.
    row_t mem [MAX_LEN];

    // Command tracking and table state.
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic                  kind_reg;
    logic [3:0]            cur_slot_reg;
    logic [SLOT_COUNT-1:0] still_reg;
    logic [SLOT_COUNT-1:0] slot_valid_reg;
    logic [LEN_W-1:0]      len_reg [SLOT_COUNT];

    // Request in flight.
    logic [7:0]            data_q;
    logic                  last_q;
    logic                  kind_q;
    logic                  first_q;
    logic                  pos_lt_q;
    logic [INC_W-1:0]      pos_inc_q;
    logic [SLOT_COUNT-1:0] sel_q;
    logic [SLOT_COUNT-1:0] len_eq_q;
    logic [SLOT_COUNT-1:0] len_gt_q;
    row_t                  row_q;

    // Result registers.
    status_t               status_reg;
    logic [2:0]            line_reg;
    logic                  mode_reg;

    // Capture side.
    logic                  first;
    logic                  kind_eff;
    logic [3:0]            slot_eff;
    logic                  pos_lt;
    logic [INC_W-1:0]      pos_inc;
    logic [ADDR_W-1:0]     addr;
    logic [SLOT_COUNT-1:0] sel;
    logic [SLOT_COUNT-1:0] len_eq;
    logic [SLOT_COUNT-1:0] len_gt;

    // Evaluate side.
    logic [SLOT_COUNT-1:0] still_base;
    logic [SLOT_COUNT-1:0] keep;
    logic [SLOT_COUNT-1:0] still_new;
    logic [SLOT_COUNT-1:0] hits;
    logic                  hit_any;
    logic [SLOT_W-1:0]     hit_idx;
    logic [7:0]            hit_wide;
    logic                  slot_ok;

    always_comb
    begin
        first    = (pos_reg == '0);
        kind_eff = first ? req_type : kind_reg;
        slot_eff = first ? slot : cur_slot_reg;
        pos_lt   = (pos_reg < POS_W'(MAX_LEN));
        pos_inc  = INC_W'(pos_reg) + INC_W'(1);
        addr     = pos_reg[ADDR_W-1:0];
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            sel[s]    = (CMP_W'(slot_eff) == CMP_W'(s));
            len_eq[s] = (INC_W'(len_reg[s]) == pos_inc);
            len_gt[s] = (POS_W'(len_reg[s]) > pos_reg);
        end
        if (last)
        begin
            pos_next = '0;
        end
        else if (pos_reg <= POS_W'(MAX_LEN))
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_comb
    begin
        still_base = first_q ? '1 : still_reg;
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            keep[s] = slot_valid_reg[s] && pos_lt_q && len_gt_q[s]
                      && (row_q[s] == data_q);
        end
        still_new = still_base & keep;
        hits      = still_new & len_eq_q;
        hit_any   = |hits;
        hit_idx   = '0;
        // The lowest matching slot wins.
        for (int s = SLOT_COUNT - 1; s >= 0; s--)
        begin
            if (hits[s])
            begin
                hit_idx = SLOT_W'(s);
            end
        end
        hit_wide = 8'(hit_idx);
        slot_ok  = |sel_q;
    end

    // Pattern memory and the request in flight.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            if (kind_eff == KIND_LEARN && pos_lt)
            begin
                for (int s = 0; s < SLOT_COUNT; s++)
                begin
                    if (sel[s])
                    begin
                        mem[addr][s] <= data_byte;
                    end
                end
            end
            if (pos_lt)
            begin
                row_q <= mem[addr];
            end
            data_q    <= data_byte;
            last_q    <= last;
            kind_q    <= kind_eff;
            first_q   <= first;
            pos_lt_q  <= pos_lt;
            pos_inc_q <= pos_inc;
            sel_q     <= sel;
            len_eq_q  <= len_eq;
            len_gt_q  <= len_gt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            kind_reg       <= KIND_LEARN;
            cur_slot_reg   <= '0;
            still_reg      <= '1;
            slot_valid_reg <= '0;
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                len_reg[s] <= '0;
            end
            status_reg     <= STATUS_STORED;
            line_reg       <= '0;
            mode_reg       <= 1'b0;
        end
        else
        begin
            if (ctl.capture)
            begin
                pos_reg      <= pos_next;
                kind_reg     <= kind_eff;
                cur_slot_reg <= slot_eff;
            end
            if (ctl.commit)
            begin
                if (kind_q == KIND_MATCH)
                begin
                    still_reg <= still_new;
                end
                if (last_q)
                begin
                    still_reg <= '1;
                    line_reg  <= '0;
                    mode_reg  <= 1'b0;
                    if (kind_q == KIND_LEARN)
                    begin
                        if (!slot_ok)
                        begin
                            status_reg <= STATUS_REJECTED;
                        end
                        else if (!pos_lt_q)
                        begin
                            // Too long: the slot is dropped rather than kept.
                            for (int s = 0; s < SLOT_COUNT; s++)
                            begin
                                if (sel_q[s])
                                begin
                                    slot_valid_reg[s] <= 1'b0;
                                    len_reg[s]        <= '0;
                                end
                            end
                            status_reg <= STATUS_REJECTED;
                        end
                        else
                        begin
                            for (int s = 0; s < SLOT_COUNT; s++)
                            begin
                                if (sel_q[s])
                                begin
                                    slot_valid_reg[s] <= 1'b1;
                                    len_reg[s]        <= LEN_W'(pos_inc_q);
                                end
                            end
                            status_reg <= STATUS_STORED;
                        end
                    end
                    else if (hit_any)
                    begin
                        status_reg <= STATUS_MATCHED;
                        line_reg   <= hit_wide[3:1];
                        mode_reg   <= hit_wide[0];
                    end
                    else
                    begin
                        status_reg <= STATUS_NO_MATCH;
                    end
                end
            end
        end
    end

    assign sts.last   = last_q;
    assign status     = status_reg;
    assign line_index = line_reg;
    assign line_mode  = mode_reg;

`ifndef SYNTH
    // The final byte of a command always returns the position to the start.
    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.capture && last) |=> (pos_reg == '0))
        else $error("byte position not cleared after final byte");

    // A learn that fits in the table leaves its slot valid.
    a_learn_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit && last_q && kind_q == KIND_LEARN && pos_lt_q && slot_ok)
        |=> ((sel_q & slot_valid_reg) == sel_q))
        else $error("learned slot not marked valid");

    // Only a match result carries a line and a mode.
    a_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg != STATUS_MATCHED) |-> (line_reg == '0 && !mode_reg))
        else $error("line fields set without a match");
`endif

endmodule

@@ sv/learned_command_matcher.sv @@
// ============================================================================
// learned_command_matcher: table of learned command byte strings
// Learns byte strings into slots and matches incoming commands against all
// slots in parallel, reporting the output line and mode of the lowest hit.
// ============================================================================
// Result: the strobe rises once the final byte of a command has been captured
//   and evaluated, with the result valid beside it; other bytes give none.
// Each byte passes a memory read, then a compare, before the next is taken;
//   busy is high in between. The receiver cannot stall: done lasts one cycle.
// Reset: asynchronous, active low; all slots become invalid with zero length
//   and no command is in progress; pattern bytes are not cleared.
module learned_command_matcher
    import lcm_pkg::*;
#(
    parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT,
    parameter int MAX_LEN    = DEFAULT_MAX_LEN
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       req_type,
    input  logic [3:0] slot,
    input  logic [7:0] data_byte,
    input  logic       last,
    output logic       done,
    output logic [1:0] status,
    output logic [2:0] line_index,
    output logic       line_mode
);

    // Commands from the controller and status from the datapath. The
    // controller owns the handshake; the datapath owns all table state.
    lcm_ctl_t ctl;
    lcm_sts_t sts;

    // The controller accepts a request when idle, then evaluates it while
    // busy holds the sender off. When the request closed a command, it
    // raises the result strobe in the cycle after evaluation.
    lcm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // The datapath latches the kind and slot of a command from its first
    // byte. On capture it writes a learn byte into the pattern memory, or
    // reads the whole row of the current byte position for a match. On
    // commit it narrows the set of slots still matching and, on the final
    // byte, stores the learned length or picks the lowest exact hit.
    lcm_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .MAX_LEN    (MAX_LEN)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .req_type   (req_type),
        .slot       (slot),
        .data_byte  (data_byte),
        .last       (last),
        .status     (status),
        .line_index (line_index),
        .line_mode  (line_mode)
    );

endmodule

@@ tb/sv/learned_command_matcher_checker.sv @@
// ============================================================================
// learned_command_matcher_checker: result predictor and scoreboard
// Watches the request and result channels of the learned command matcher,
// keeps its own copy of the learned string table, predicts the result of
// every command and compares each result strobe with the oldest prediction.
// ============================================================================
module learned_command_matcher_checker
    import lcm_pkg::*;
#(
    parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT,
    parameter int MAX_LEN    = DEFAULT_MAX_LEN
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       req_type,
    input  logic [3:0] slot,
    input  logic [7:0] data_byte,
    input  logic       last,
    input  logic       done,
    input  logic [1:0] status,
    input  logic [2:0] line_index,
    input  logic       line_mode,
    output int         mismatch_count,
    output int         pending_count
);

    typedef struct packed {
        status_t    status;
        logic [2:0] line_index;
        logic       line_mode;
    } line_result_t;

    // Shadow of the string table and of the command in progress.
    logic [7:0]            learned_bytes [SLOT_COUNT][MAX_LEN];
    int                    learned_len   [SLOT_COUNT];
    bit                    learned_ok    [SLOT_COUNT];
    int                    cmd_pos;
    logic [SLOT_COUNT-1:0] hit_mask;
    logic                  cmd_kind;
    logic [3:0]            cmd_slot;

    line_result_t          awaited_results [$];

    task automatic note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Applies one accepted request to the shadow table and queues the result
    // that a final byte produces.
    task automatic take_request(logic kind_in, logic [3:0] slot_in,
                                logic [7:0] data_in, logic last_in);
        int           pos;
        bit           found;
        line_result_t res;
        if (cmd_pos == 0)
        begin
            cmd_kind = kind_in;
            cmd_slot = slot_in;
            hit_mask = '1;
        end
        pos = cmd_pos;
        if (cmd_kind == KIND_LEARN)
        begin
            if (int'(cmd_slot) < SLOT_COUNT && pos < MAX_LEN)
            begin
                learned_bytes[cmd_slot][pos] = data_in;
            end
        end
        else
        begin
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                if (!(learned_ok[s] && pos < MAX_LEN && pos < learned_len[s]
                      && learned_bytes[s][pos] == data_in))
                begin
                    hit_mask[s] = 1'b0;
                end
            end
        end
        if (cmd_pos <= MAX_LEN)
        begin
            cmd_pos++;
        end
        if (last_in)
        begin
            cmd_pos = 0;
            res = '{status: STATUS_NO_MATCH, line_index: 3'd0, line_mode: 1'b0};
            if (cmd_kind == KIND_LEARN)
            begin
                if (int'(cmd_slot) >= SLOT_COUNT)
                begin
                    res.status = STATUS_REJECTED;
                end
                else if (pos + 1 > MAX_LEN)
                begin
                    learned_ok[cmd_slot]  = 1'b0;
                    learned_len[cmd_slot] = 0;
                    res.status = STATUS_REJECTED;
                end
                else
                begin
                    learned_len[cmd_slot] = pos + 1;
                    learned_ok[cmd_slot]  = 1'b1;
                    res.status = STATUS_STORED;
                end
            end
            else
            begin
                found = 1'b0;
                for (int s = 0; s < SLOT_COUNT; s++)
                begin
                    if (!found && hit_mask[s] && learned_len[s] == pos + 1)
                    begin
                        found = 1'b1;
                        res.status     = STATUS_MATCHED;
                        res.line_index = 3'(s / 2);
                        res.line_mode  = 1'(s % 2);
                    end
                end
            end
            hit_mask = '1;
            awaited_results.push_back(res);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_result_t exp_res;
        if (!rst_n)
        begin
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                learned_len[s] = 0;
                learned_ok[s]  = 1'b0;
                for (int p = 0; p < MAX_LEN; p++)
                begin
                    learned_bytes[s][p] = 8'h00;
                end
            end
            cmd_pos  = 0;
            hit_mask = '1;
            cmd_kind = KIND_LEARN;
            cmd_slot = 4'd0;
            awaited_results.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end
        else
        begin
            // A result always belongs to a command finished earlier, so it is
            // compared before this edge's request is taken.
            if (done === 1'b1)
            begin
                if (awaited_results.size() == 0)
                begin
                    note_mismatch($sformatf("result with none expected: status=%0d line=%0d mode=%0d",
                                            status, line_index, line_mode));
                end
                else
                begin
                    exp_res = awaited_results.pop_front();
                    if (status !== exp_res.status || line_index !== exp_res.line_index
                        || line_mode !== exp_res.line_mode)
                    begin
                        note_mismatch($sformatf(
                            "expected status=%s line=%0d mode=%0d, got status=%0d line=%0d mode=%0d",
                            exp_res.status.name(), exp_res.line_index, exp_res.line_mode,
                            status, line_index, line_mode));
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                take_request(req_type, slot, data_byte, last);
            end
            pending_count = awaited_results.size();
        end
    end

endmodule

@@ tb/sv/learned_command_matcher_tb.sv @@
// ============================================================================
// learned_command_matcher_tb: top level of the matcher testbench
// Drives learn and match commands byte by byte through the start/busy
// handshake, first a directed sequence and then a random mix that mostly
// replays, truncates, extends or corrupts learned strings. A checker beside
// the block predicts and compares every result; this module gives the verdict.
// ============================================================================
module learned_command_matcher_tb;
    import lcm_pkg::*;

    localparam int MAX_LEN      = DEFAULT_MAX_LEN;
    localparam int TARGET_ITEMS = 1550;

    // Every input of the block has a known value from time zero.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic       req_type  = 1'b0;
    logic [3:0] slot      = 4'd0;
    logic [7:0] data_byte = 8'h00;
    logic       last      = 1'b0;

    logic       busy;
    logic       done;
    logic [1:0] status;
    logic [2:0] line_index;
    logic       line_mode;

    int         mismatch_count;
    int         pending_count;

    // Stimulus bookkeeping: the command being built, the number of requests
    // accepted so far, and what each slot was last taught (length zero means
    // the slot holds nothing usable). The last is only used to shape stimulus.
    logic [7:0] cmd_buf   [64];
    int         cmd_len;
    int         items_sent;
    logic [7:0] known_str [16][64];
    int         known_len [16];

    learned_command_matcher u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .slot       (slot),
        .data_byte  (data_byte),
        .last       (last),
        .done       (done),
        .status     (status),
        .line_index (line_index),
        .line_mode  (line_mode)
    );

    learned_command_matcher_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .slot           (slot),
        .data_byte      (data_byte),
        .last           (last),
        .done           (done),
        .status         (status),
        .line_index     (line_index),
        .line_mode      (line_mode),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hard stop in case the block hangs or a result never arrives.
    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

    // Picks a byte that is often one of a few shared values, so that learned
    // strings collide and share prefixes, and otherwise anything at all.
    function automatic logic [7:0] pick_byte();
        logic [7:0] common [6];
        common = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80};
        if ($urandom_range(0, 1) == 0)
        begin
            return common[$urandom_range(0, 5)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Presents one request and holds it until the block takes it. Before the
    // request, the sender sometimes goes quiet; since each byte passes through
    // a read and a compare phase inside the block, gaps of varying length land
    // on both phases. A window in the middle of the run has no gaps at all.
    task automatic send_byte(logic k, logic [3:0] s, logic [7:0] d, logic l);
        if ((items_sent < 500 || items_sent >= 850) && $urandom_range(0, 99) < 13)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start     <= 1'b1;
        req_type  <= k;
        slot      <= s;
        data_byte <= d;
        last      <= l;
        @(posedge clk);
        // busy read here is its value before this edge, the one that decides
        // whether the request was taken.
        while (busy)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Sends cmd_buf as one command. Only the first byte carries the kind and
    // the slot; the later bytes get random values there, which the block has
    // to ignore.
    task automatic send_command(logic k, logic [3:0] s);
        for (int i = 0; i < cmd_len; i++)
        begin
            if (i == 0)
            begin
                send_byte(k, s, cmd_buf[0], cmd_len == 1);
            end
            else
            begin
                send_byte(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                          cmd_buf[i], i == cmd_len - 1);
            end
        end
    endtask

    task automatic run_learn(logic [3:0] s);
        send_command(KIND_LEARN, s);
        // An overlong string invalidates the slot instead of being kept.
        if (cmd_len <= MAX_LEN)
        begin
            known_len[s] = cmd_len;
            for (int i = 0; i < cmd_len; i++)
            begin
                known_str[s][i] = cmd_buf[i];
            end
        end
        else
        begin
            known_len[s] = 0;
        end
    endtask

    task automatic run_match();
        send_command(KIND_MATCH, 4'($urandom_range(0, 15)));
    endtask

    // Random learn: mostly short strings, with a share at the longest legal
    // length and some that are one or more bytes too long.
    task automatic random_learn();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            cmd_len = $urandom_range(1, 4);
        end
        else if (pick < 80)
        begin
            cmd_len = $urandom_range(5, MAX_LEN - 1);
        end
        else if (pick < 92)
        begin
            cmd_len = MAX_LEN;
        end
        else if (pick < 97)
        begin
            cmd_len = MAX_LEN + 1;
        end
        else
        begin
            cmd_len = $urandom_range(MAX_LEN + 2, MAX_LEN + 8);
        end
        for (int i = 0; i < cmd_len; i++)
        begin
            cmd_buf[i] = pick_byte();
        end
        run_learn(4'($urandom_range(0, 15)));
    endtask

    // Match built from a learned string: sent as is, cut short by a byte,
    // grown by a byte, or with one bit flipped. Growing a string of the
    // longest legal length gives an overlong match.
    task automatic replay_match();
        int base;
        int s;
        int pick;
        int pos;
        base = $urandom_range(0, 15);
        s = -1;
        for (int i = 0; i < 16; i++)
        begin
            if (s < 0 && known_len[(base + i) % 16] > 0)
            begin
                s = (base + i) % 16;
            end
        end
        if (s < 0)
        begin
            cmd_len = $urandom_range(1, 4);
            for (int i = 0; i < cmd_len; i++)
            begin
                cmd_buf[i] = pick_byte();
            end
        end
        else
        begin
            cmd_len = known_len[s];
            for (int i = 0; i < cmd_len; i++)
            begin
                cmd_buf[i] = known_str[s][i];
            end
            pick = $urandom_range(0, 99);
            if (pick >= 60 && pick < 70 && cmd_len > 1)
            begin
                cmd_len--;
            end
            else if (pick >= 70 && pick < 80)
            begin
                cmd_buf[cmd_len] = pick_byte();
                cmd_len++;
            end
            else if (pick >= 80)
            begin
                pos = $urandom_range(0, cmd_len - 1);
                cmd_buf[pos][$urandom_range(0, 7)] ^= 1'b1;
            end
        end
        run_match();
    endtask

    // Match with no relation to the table: short noise, or overlong.
    task automatic noise_match();
        if ($urandom_range(0, 99) < 85)
        begin
            cmd_len = $urandom_range(1, 4);
        end
        else
        begin
            cmd_len = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
        end
        for (int i = 0; i < cmd_len; i++)
        begin
            cmd_buf[i] = pick_byte();
        end
        run_match();
    endtask

    initial
    begin
        int pick;
        items_sent = 0;
        for (int s = 0; s < 16; s++)
        begin
            known_len[s] = 0;
        end

        // Reset is held low from time zero and released on a clock edge.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A match against the empty table finds nothing.
        cmd_len = 1;
        cmd_buf[0] = 8'h00;
        run_match();
        // Learn into the lowest and the highest slot, with extreme bytes.
        cmd_buf[0] = 8'hFF;
        run_learn(4'd0);
        cmd_len = 3;
        cmd_buf[0] = 8'h00;
        cmd_buf[1] = 8'hFF;
        cmd_buf[2] = 8'hA5;
        run_learn(4'd15);
        // Exact hits on both, the highest slot giving line 7 and mode 1.
        cmd_len = 1;
        cmd_buf[0] = 8'hFF;
        run_match();
        cmd_len = 3;
        cmd_buf[0] = 8'h00;
        cmd_buf[1] = 8'hFF;
        cmd_buf[2] = 8'hA5;
        run_match();
        // A prefix of a learned string has the wrong length and must miss.
        cmd_len = 2;
        run_match();
        // The same string in two slots: the lower slot wins.
        cmd_len = 1;
        cmd_buf[0] = 8'hFF;
        run_learn(4'd1);
        run_match();
        // A string one byte too long is rejected and invalidates its slot,
        // so the next match lands on the second copy.
        cmd_len = MAX_LEN + 1;
        for (int i = 0; i < cmd_len; i++)
        begin
            cmd_buf[i] = 8'(i * 37);
        end
        run_learn(4'd0);
        cmd_len = 1;
        cmd_buf[0] = 8'hFF;
        run_match();

        // Random part: mostly learns and replays of learned strings, with
        // some unrelated matches mixed in.
        while (items_sent < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                random_learn();
            end
            else if (pick < 80)
            begin
                replay_match();
            end
            else
            begin
                noise_match();
            end
        end
        start <= 1'b0;

        // Drain: wait for every predicted result, then let the clock run on so
        // that a stray extra strobe would still be caught.
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
